// ===== sv/tss_pkg.sv =====
package tss_pkg;

    localparam int STATE_W = 5;
    localparam int MODE_W  = 3;
    localparam int DELAY_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W = 2;

    // sequencer state codes
    localparam logic [STATE_W-1:0] ST_START       = 5'd0;
    localparam logic [STATE_W-1:0] ST_LINE_WAIT   = 5'd1;
    localparam logic [STATE_W-1:0] ST_TO_LINE     = 5'd2;
    localparam logic [STATE_W-1:0] ST_ON_LINE     = 5'd3;
    localparam logic [STATE_W-1:0] ST_LINE_LOST   = 5'd4;
    localparam logic [STATE_W-1:0] ST_TO_OFF      = 5'd5;
    localparam logic [STATE_W-1:0] ST_AT_OFF      = 5'd6;
    localparam logic [STATE_W-1:0] ST_LSTAB_A     = 5'd7;
    localparam logic [STATE_W-1:0] ST_LSTAB_B     = 5'd8;
    localparam logic [STATE_W-1:0] ST_LSTAB_C     = 5'd9;
    localparam logic [STATE_W-1:0] ST_LSTAB_D     = 5'd10;
    localparam logic [STATE_W-1:0] ST_GEN_WAIT    = 5'd11;
    localparam logic [STATE_W-1:0] ST_TO_GEN      = 5'd12;
    localparam logic [STATE_W-1:0] ST_ON_GEN      = 5'd13;
    localparam logic [STATE_W-1:0] ST_GEN_LOST    = 5'd14;
    localparam logic [STATE_W-1:0] ST_FAULT_OFF   = 5'd15;
    localparam logic [STATE_W-1:0] ST_FORCED_GEN  = 5'd16;
    localparam logic [STATE_W-1:0] ST_FORCED_LINE = 5'd17;
    localparam logic [STATE_W-1:0] ST_FORCED_OFF  = 5'd18;

    // operating modes
    localparam logic [MODE_W-1:0] MODE_AUTO        = 3'd0;
    localparam logic [MODE_W-1:0] MODE_FORCED_GEN  = 3'd1;
    localparam logic [MODE_W-1:0] MODE_FORCED_LINE = 3'd2;
    localparam logic [MODE_W-1:0] MODE_FORCED_OFF  = 3'd3;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_DELAY = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_DELAY  = 2'd2;

    localparam logic [DELAY_W-1:0] SHORT_DELAY_RST = 16'd5000;
    localparam logic [DELAY_W-1:0] LONG_DELAY_RST  = 16'd10000;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              line_ok;
        logic              gen_ok;
        logic              line_closed;
        logic              off_closed;
        logic              gen_closed;
    } sample_t;

    typedef struct packed {
        logic               relay_line;
        logic               relay_off;
        logic               relay_gen;
        logic               on_line_good;
        logic               at_off_good;
        logic               on_gen_good;
        logic               gen_request;
        logic [STATE_W-1:0] state_code;
    } result_t;

    // flow control between the input stage and the result stage
    typedef struct packed {
        logic out_free;
        logic step;
    } flow_t;

endpackage

// ===== sv/tss_in_reg.sv =====
module tss_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  tss_pkg::sample_t sample,
    input  tss_pkg::flow_t   flow,
    output logic             in_stall,
    output logic             s1_valid,
    output tss_pkg::sample_t s1_data
);

    logic             valid_reg;
    logic             valid_next;
    tss_pkg::sample_t data_reg;
    logic             load;

    // hold the captured transaction while the result stage is full
    assign in_stall   = valid_reg && !flow.out_free;
    assign load       = in_valid && !in_stall;
    assign valid_next = load || (valid_reg && !flow.out_free);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= sample;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

// ===== sv/tss_core.sv =====
module tss_core (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_valid,
    input  logic [tss_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tss_pkg::DELAY_W-1:0]     cfg_data,
    input  tss_pkg::flow_t                  flow,
    input  tss_pkg::sample_t                s1_data,
    output tss_pkg::result_t                result
);

    logic [tss_pkg::STATE_W-1:0] state_reg;
    logic [tss_pkg::STATE_W-1:0] state_next;
    logic [tss_pkg::TIME_W-1:0]  timer_reg;
    logic [tss_pkg::TIME_W-1:0]  timer_next;
    logic [tss_pkg::MODE_W-1:0]  applied_mode_reg;
    logic                        applied_valid_reg;
    logic [tss_pkg::MODE_W-1:0]  mode_reg;
    logic [tss_pkg::DELAY_W-1:0] short_delay_reg;
    logic [tss_pkg::DELAY_W-1:0] long_delay_reg;

    logic [tss_pkg::TIME_W-1:0]  elapsed;
    logic                        short_gt;
    logic                        long_gt;
    logic                        lok;
    logic                        gok;
    logic                        rl;
    logic                        ro;
    logic                        rg;
    logic                        lgood;
    logic                        ogood;
    logic                        ggood;

    assign lok = s1_data.line_ok;
    assign gok = s1_data.gen_ok;

    // A mode change only restarts the timer on the way into states that never
    // check it, so the elapsed time can use the stored start directly.
    assign elapsed  = s1_data.now_ms - timer_reg;
    assign short_gt = elapsed > {{(tss_pkg::TIME_W-tss_pkg::DELAY_W){1'b0}}, short_delay_reg};
    assign long_gt  = elapsed > {{(tss_pkg::TIME_W-tss_pkg::DELAY_W){1'b0}}, long_delay_reg};

    always_comb
    begin
        state_next = state_reg;
        timer_next = timer_reg;
        rl    = 1'b0;
        ro    = 1'b0;
        rg    = 1'b0;
        lgood = 1'b0;
        ogood = 1'b0;
        ggood = 1'b0;

        if (!applied_valid_reg || applied_mode_reg != mode_reg)
        begin
            case (mode_reg)
                tss_pkg::MODE_AUTO:
                begin
                    if (state_reg == tss_pkg::ST_FORCED_GEN && gok)
                    begin
                        timer_next = s1_data.now_ms;
                        state_next = tss_pkg::ST_TO_GEN;
                    end
                    else if (state_reg == tss_pkg::ST_FORCED_LINE && lok)
                    begin
                        timer_next = s1_data.now_ms;
                        state_next = tss_pkg::ST_TO_LINE;
                    end
                    else
                    begin
                        state_next = tss_pkg::ST_START;
                    end
                end
                tss_pkg::MODE_FORCED_GEN:  state_next = tss_pkg::ST_FORCED_GEN;
                tss_pkg::MODE_FORCED_LINE: state_next = tss_pkg::ST_FORCED_LINE;
                tss_pkg::MODE_FORCED_OFF:  state_next = tss_pkg::ST_FORCED_OFF;
                default: ;
            endcase
        end

        // later tests override earlier ones, in priority order
        case (state_next)
            tss_pkg::ST_START:
            begin
                timer_next = s1_data.now_ms;
                state_next = lok ? tss_pkg::ST_LINE_WAIT : tss_pkg::ST_LINE_LOST;
            end
            tss_pkg::ST_LINE_WAIT:
            begin
                if (!lok) state_next = tss_pkg::ST_START;
                if (short_gt) state_next = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_TO_LINE:
            begin
                rl = 1'b1;
                if (s1_data.line_closed) state_next = tss_pkg::ST_ON_LINE;
                if (!lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_LINE_WAIT;
                end
            end
            tss_pkg::ST_ON_LINE:
            begin
                lgood      = 1'b1;
                timer_next = s1_data.now_ms;
                if (!lok) state_next = tss_pkg::ST_LINE_LOST;
            end
            tss_pkg::ST_LINE_LOST:
            begin
                if (lok) state_next = tss_pkg::ST_ON_LINE;
                if (short_gt)
                begin
                    state_next = tss_pkg::ST_TO_OFF;
                    timer_next = s1_data.now_ms;
                end
            end
            tss_pkg::ST_TO_OFF:
            begin
                ro = 1'b1;
                if (s1_data.off_closed) state_next = tss_pkg::ST_AT_OFF;
                if (lok) state_next = tss_pkg::ST_LSTAB_A;
                if (gok) state_next = tss_pkg::ST_GEN_WAIT;
                if (short_gt) state_next = tss_pkg::ST_FAULT_OFF;
            end
            tss_pkg::ST_AT_OFF:
            begin
                ogood      = 1'b1;
                timer_next = s1_data.now_ms;
                if (lok) state_next = tss_pkg::ST_LSTAB_A;
                if (gok) state_next = tss_pkg::ST_GEN_WAIT;
            end
            tss_pkg::ST_LSTAB_A:
            begin
                // a restarted timer cannot have run out yet
                if (!lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_TO_OFF;
                end
                if (lok && short_gt) state_next = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_B:
            begin
                if (!lok) state_next = tss_pkg::ST_GEN_WAIT;
                if (short_gt) state_next = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_C:
            begin
                if (!lok) state_next = tss_pkg::ST_ON_GEN;
                if (short_gt) state_next = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_D:
            begin
                if (!lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_GEN_LOST;
                end
                if (lok && short_gt) state_next = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_GEN_WAIT:
            begin
                if (lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_LSTAB_B;
                end
                if (!gok) state_next = tss_pkg::ST_AT_OFF;
                if (!lok && long_gt)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_TO_GEN;
                end
            end
            tss_pkg::ST_TO_GEN:
            begin
                rg         = 1'b1;
                timer_next = s1_data.now_ms;
                if (s1_data.gen_closed) state_next = tss_pkg::ST_ON_GEN;
                if (!gok) state_next = tss_pkg::ST_AT_OFF;
                if (lok) state_next = tss_pkg::ST_LSTAB_C;
            end
            tss_pkg::ST_ON_GEN:
            begin
                ggood      = 1'b1;
                timer_next = s1_data.now_ms;
                if (lok) state_next = tss_pkg::ST_LSTAB_C;
                if (!gok) state_next = tss_pkg::ST_GEN_LOST;
            end
            tss_pkg::ST_GEN_LOST:
            begin
                if (lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_LSTAB_D;
                end
                if (gok) state_next = tss_pkg::ST_ON_GEN;
                if (!lok && short_gt) state_next = tss_pkg::ST_FAULT_OFF;
            end
            tss_pkg::ST_FAULT_OFF:
            begin
                ro = 1'b1;
                if (s1_data.off_closed) state_next = tss_pkg::ST_AT_OFF;
                if (lok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_LSTAB_A;
                end
                if (gok)
                begin
                    timer_next = s1_data.now_ms;
                    state_next = tss_pkg::ST_GEN_WAIT;
                end
            end
            tss_pkg::ST_FORCED_GEN:  rg = !s1_data.gen_closed;
            tss_pkg::ST_FORCED_LINE: rl = !s1_data.line_closed;
            tss_pkg::ST_FORCED_OFF:  ro = !s1_data.off_closed;
            default:                 state_next = tss_pkg::ST_START;
        endcase
    end

    assign result.relay_line   = rl;
    assign result.relay_off    = ro;
    assign result.relay_gen    = rg;
    assign result.on_line_good = lgood;
    assign result.at_off_good  = ogood;
    assign result.on_gen_good  = ggood;
    assign result.gen_request  = state_next inside
                                 {[tss_pkg::ST_TO_OFF:tss_pkg::ST_FORCED_GEN]};
    assign result.state_code   = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= tss_pkg::ST_START;
            timer_reg         <= '0;
            applied_mode_reg  <= tss_pkg::MODE_AUTO;
            applied_valid_reg <= 1'b0;
        end
        else if (flow.step)
        begin
            state_reg         <= state_next;
            timer_reg         <= timer_next;
            applied_mode_reg  <= mode_reg;
            applied_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= tss_pkg::MODE_AUTO;
            short_delay_reg <= tss_pkg::SHORT_DELAY_RST;
            long_delay_reg  <= tss_pkg::LONG_DELAY_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                tss_pkg::CFG_MODE:        mode_reg        <= cfg_data[tss_pkg::MODE_W-1:0];
                tss_pkg::CFG_SHORT_DELAY: short_delay_reg <= cfg_data;
                tss_pkg::CFG_LONG_DELAY:  long_delay_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // the state register never leaves the defined code range
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= tss_pkg::ST_FORCED_OFF)
        else $error("sequencer state out of range");

    // a step always leaves the mode marked as applied
    a_mode_applied: assert property (@(posedge clk) disable iff (!rst_n)
        flow.step |=> applied_valid_reg && applied_mode_reg == $past(mode_reg))
        else $error("mode not recorded after step");

    // state and timer only move on a step
    a_hold_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !flow.step |=> $stable(state_reg) && $stable(timer_reg))
        else $error("sequencer state moved without a step");

endmodule

// ===== sv/tss_out_reg.sv =====
module tss_out_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  tss_pkg::result_t result,
    input  logic             s1_valid,
    input  logic             out_stall,
    output tss_pkg::flow_t   flow,
    output logic             out_valid,
    output tss_pkg::result_t out_data
);

    logic             valid_reg;
    logic             valid_next;
    tss_pkg::result_t data_reg;

    assign flow.out_free = !valid_reg || !out_stall;
    assign flow.step     = s1_valid && flow.out_free;
    assign valid_next    = flow.step || (valid_reg && out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (flow.step)
        begin
            data_reg <= result;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== sv/transfer_switch_sequencer.sv =====
// Flow: a transaction accepted into the input register is stepped through the sequencer into the result register.
// Throughput: one transaction per cycle while out_stall is low; the sequencer state updates
// in the same cycle as an item moves from the input register to the result register.
// Reset (rst_n, asynchronous, active low): state to start, timer start to zero,
// mode auto with no mode yet applied, delays 5000 and 10000 ms, both stages empty.
module transfer_switch_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [tss_pkg::TIME_W-1:0]    now_ms,
    input  logic                          line_ok,
    input  logic                          gen_ok,
    input  logic                          line_closed,
    input  logic                          off_closed,
    input  logic                          gen_closed,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          relay_line,
    output logic                          relay_off,
    output logic                          relay_gen,
    output logic                          on_line_good,
    output logic                          at_off_good,
    output logic                          on_gen_good,
    output logic                          gen_request,
    output logic [tss_pkg::STATE_W-1:0]   state_code,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tss_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tss_pkg::DELAY_W-1:0]   cfg_data
);

    tss_pkg::sample_t sample;
    tss_pkg::sample_t s1_data;
    tss_pkg::result_t result;
    tss_pkg::result_t out_data;
    tss_pkg::flow_t   flow;
    logic             s1_valid;

    assign cfg_ready = 1'b1;

    assign sample.now_ms      = now_ms;
    assign sample.line_ok     = line_ok;
    assign sample.gen_ok      = gen_ok;
    assign sample.line_closed = line_closed;
    assign sample.off_closed  = off_closed;
    assign sample.gen_closed  = gen_closed;

    tss_in_reg u_in_reg (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .sample   (sample),
        .flow     (flow),
        .in_stall (in_stall),
        .s1_valid (s1_valid),
        .s1_data  (s1_data)
    );

    tss_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .flow      (flow),
        .s1_data   (s1_data),
        .result    (result)
    );

    tss_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .s1_valid  (s1_valid),
        .out_stall (out_stall),
        .flow      (flow),
        .out_valid (out_valid),
        .out_data  (out_data)
    );

    assign relay_line   = out_data.relay_line;
    assign relay_off    = out_data.relay_off;
    assign relay_gen    = out_data.relay_gen;
    assign on_line_good = out_data.on_line_good;
    assign at_off_good  = out_data.at_off_good;
    assign on_gen_good  = out_data.on_gen_good;
    assign gen_request  = out_data.gen_request;
    assign state_code   = out_data.state_code;

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    localparam logic [tss_pkg::MODE_W-1:0] MODE_NO_FORCE = 3'd4;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid = 1'b0;
    logic                          in_stall;
    logic [tss_pkg::TIME_W-1:0]    now_ms = '0;
    logic                          line_ok = 1'b0;
    logic                          gen_ok = 1'b0;
    logic                          line_closed = 1'b0;
    logic                          off_closed = 1'b0;
    logic                          gen_closed = 1'b0;
    logic                          out_valid;
    logic                          out_stall = 1'b0;
    logic                          relay_line;
    logic                          relay_off;
    logic                          relay_gen;
    logic                          on_line_good;
    logic                          at_off_good;
    logic                          on_gen_good;
    logic                          gen_request;
    logic [tss_pkg::STATE_W-1:0]   state_code;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [tss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
    logic [tss_pkg::DELAY_W-1:0]   cfg_data = '0;

    transfer_switch_sequencer dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .now_ms       (now_ms),
        .line_ok      (line_ok),
        .gen_ok       (gen_ok),
        .line_closed  (line_closed),
        .off_closed   (off_closed),
        .gen_closed   (gen_closed),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .relay_line   (relay_line),
        .relay_off    (relay_off),
        .relay_gen    (relay_gen),
        .on_line_good (on_line_good),
        .at_off_good  (at_off_good),
        .on_gen_good  (on_gen_good),
        .gen_request  (gen_request),
        .state_code   (state_code),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial forever #2 clk = ~clk;

    // evaluations waiting to be driven, switch outputs waiting to be seen
    tss_pkg::sample_t evals_q[$];
    tss_pkg::result_t switch_results_q[$];

    int unsigned items_total  = 0;
    int unsigned results_done = 0;
    int unsigned errors       = 0;

    // sequencer shadow
    logic [tss_pkg::STATE_W-1:0] sw_state     = tss_pkg::ST_START;
    logic [tss_pkg::TIME_W-1:0]  timer_ms     = '0;
    logic [tss_pkg::MODE_W-1:0]  active_mode  = tss_pkg::MODE_AUTO;
    logic                        mode_applied = 1'b0;
    logic [tss_pkg::MODE_W-1:0]  mode_cfg     = tss_pkg::MODE_AUTO;
    logic [tss_pkg::DELAY_W-1:0] short_cfg    = tss_pkg::SHORT_DELAY_RST;
    logic [tss_pkg::DELAY_W-1:0] long_cfg     = tss_pkg::LONG_DELAY_RST;

    // plant that feeds the random evaluations
    logic [tss_pkg::TIME_W-1:0] plant_ms   = 32'hFFF0_0000;
    logic                       plant_line = 1'b1;
    logic                       plant_gen  = 1'b0;
    int unsigned                plant_pos  = 3;

    logic [tss_pkg::MODE_W-1:0] forced_modes[3] = '{tss_pkg::MODE_FORCED_GEN,
                                                    tss_pkg::MODE_FORCED_LINE,
                                                    tss_pkg::MODE_FORCED_OFF};

    function automatic logic waited_past(input logic [tss_pkg::TIME_W-1:0] t_now,
                                         input logic [tss_pkg::TIME_W-1:0] t_start,
                                         input logic [tss_pkg::DELAY_W-1:0] lim);
        logic [tss_pkg::TIME_W-1:0] elapsed;
        elapsed = t_now - t_start;
        return elapsed > {16'd0, lim};
    endfunction

    function automatic tss_pkg::result_t step_sequencer(input tss_pkg::sample_t smp);
        tss_pkg::result_t            r;
        logic [tss_pkg::STATE_W-1:0] st;
        logic [tss_pkg::TIME_W-1:0]  t0;
        logic [tss_pkg::TIME_W-1:0]  tn;
        r  = '0;
        st = sw_state;
        t0 = timer_ms;
        tn = smp.now_ms;

        // mode change takes effect before the step
        if (!mode_applied || active_mode != mode_cfg)
        begin
            case (mode_cfg)
                tss_pkg::MODE_AUTO:
                begin
                    if (st == tss_pkg::ST_FORCED_GEN && smp.gen_ok)
                    begin
                        t0 = tn;
                        st = tss_pkg::ST_TO_GEN;
                    end
                    else if (st == tss_pkg::ST_FORCED_LINE && smp.line_ok)
                    begin
                        t0 = tn;
                        st = tss_pkg::ST_TO_LINE;
                    end
                    else
                        st = tss_pkg::ST_START;
                end
                tss_pkg::MODE_FORCED_GEN:  st = tss_pkg::ST_FORCED_GEN;
                tss_pkg::MODE_FORCED_LINE: st = tss_pkg::ST_FORCED_LINE;
                tss_pkg::MODE_FORCED_OFF:  st = tss_pkg::ST_FORCED_OFF;
                default: ;
            endcase
            active_mode  = mode_cfg;
            mode_applied = 1'b1;
        end

        case (st)
            tss_pkg::ST_START:
            begin
                t0 = tn;
                st = smp.line_ok ? tss_pkg::ST_LINE_WAIT : tss_pkg::ST_LINE_LOST;
            end
            tss_pkg::ST_LINE_WAIT:
            begin
                if (!smp.line_ok) st = tss_pkg::ST_START;
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_TO_LINE:
            begin
                r.relay_line = 1'b1;
                if (smp.line_closed) st = tss_pkg::ST_ON_LINE;
                if (!smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_LINE_WAIT;
                end
            end
            tss_pkg::ST_ON_LINE:
            begin
                r.on_line_good = 1'b1;
                t0 = tn;
                if (!smp.line_ok) st = tss_pkg::ST_LINE_LOST;
            end
            tss_pkg::ST_LINE_LOST:
            begin
                if (smp.line_ok) st = tss_pkg::ST_ON_LINE;
                if (waited_past(tn, t0, short_cfg))
                begin
                    st = tss_pkg::ST_TO_OFF;
                    t0 = tn;
                end
            end
            tss_pkg::ST_TO_OFF:
            begin
                r.relay_off = 1'b1;
                if (smp.off_closed) st = tss_pkg::ST_AT_OFF;
                if (smp.line_ok) st = tss_pkg::ST_LSTAB_A;
                if (smp.gen_ok) st = tss_pkg::ST_GEN_WAIT;
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_FAULT_OFF;
            end
            tss_pkg::ST_AT_OFF:
            begin
                r.at_off_good = 1'b1;
                t0 = tn;
                if (smp.line_ok) st = tss_pkg::ST_LSTAB_A;
                if (smp.gen_ok) st = tss_pkg::ST_GEN_WAIT;
            end
            tss_pkg::ST_LSTAB_A:
            begin
                if (!smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_TO_OFF;
                end
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_B:
            begin
                if (!smp.line_ok) st = tss_pkg::ST_GEN_WAIT;
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_C:
            begin
                if (!smp.line_ok) st = tss_pkg::ST_ON_GEN;
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_LSTAB_D:
            begin
                if (!smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_GEN_LOST;
                end
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_TO_LINE;
            end
            tss_pkg::ST_GEN_WAIT:
            begin
                if (smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_LSTAB_B;
                end
                if (!smp.gen_ok) st = tss_pkg::ST_AT_OFF;
                if (waited_past(tn, t0, long_cfg))
                begin
                    t0 = tn;
                    st = tss_pkg::ST_TO_GEN;
                end
            end
            tss_pkg::ST_TO_GEN:
            begin
                r.relay_gen = 1'b1;
                t0 = tn;
                if (smp.gen_closed) st = tss_pkg::ST_ON_GEN;
                if (!smp.gen_ok) st = tss_pkg::ST_AT_OFF;
                if (smp.line_ok) st = tss_pkg::ST_LSTAB_C;
            end
            tss_pkg::ST_ON_GEN:
            begin
                r.on_gen_good = 1'b1;
                t0 = tn;
                if (smp.line_ok) st = tss_pkg::ST_LSTAB_C;
                if (!smp.gen_ok) st = tss_pkg::ST_GEN_LOST;
            end
            tss_pkg::ST_GEN_LOST:
            begin
                if (smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_LSTAB_D;
                end
                if (smp.gen_ok) st = tss_pkg::ST_ON_GEN;
                if (waited_past(tn, t0, short_cfg)) st = tss_pkg::ST_FAULT_OFF;
            end
            tss_pkg::ST_FAULT_OFF:
            begin
                r.relay_off = 1'b1;
                if (smp.off_closed) st = tss_pkg::ST_AT_OFF;
                if (smp.line_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_LSTAB_A;
                end
                if (smp.gen_ok)
                begin
                    t0 = tn;
                    st = tss_pkg::ST_GEN_WAIT;
                end
            end
            tss_pkg::ST_FORCED_GEN:  r.relay_gen  = !smp.gen_closed;
            tss_pkg::ST_FORCED_LINE: r.relay_line = !smp.line_closed;
            tss_pkg::ST_FORCED_OFF:  r.relay_off  = !smp.off_closed;
            default:                 st = tss_pkg::ST_START;
        endcase

        sw_state      = st;
        timer_ms      = t0;
        r.gen_request = st inside {[tss_pkg::ST_TO_OFF:tss_pkg::ST_FORCED_GEN]};
        r.state_code  = st;
        return r;
    endfunction

    task automatic check_field(input string what, input int unsigned want,
                               input int unsigned got);
        if (want != got)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, what, want, got);
            errors++;
        end
    endtask

    // driver: hold a stalled transaction, then wait the drawn gap
    int unsigned send_gap   = 0;
    logic        send_burst = 1'b0;

    always @(posedge clk)
    begin : drive_evals
        tss_pkg::sample_t smp;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else if (in_valid && in_stall)
        begin
        end
        else if (send_gap != 0)
        begin
            in_valid <= 1'b0;
            send_gap <= send_gap - 1;
        end
        else if (evals_q.size() != 0)
        begin
            smp = evals_q.pop_front();
            now_ms      <= smp.now_ms;
            line_ok     <= smp.line_ok;
            gen_ok      <= smp.gen_ok;
            line_closed <= smp.line_closed;
            off_closed  <= smp.off_closed;
            gen_closed  <= smp.gen_closed;
            in_valid    <= 1'b1;
            send_gap    <= send_burst ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 29) == 0)
                send_burst <= !send_burst;
        end
        else
            in_valid <= 1'b0;
    end

    // receiver: drawn stall after each transaction, two long hold-offs
    int unsigned rx_wait  = 0;
    int unsigned rx_hold  = 0;
    int unsigned rx_taken = 0;
    logic        rx_burst = 1'b0;

    always @(posedge clk)
    begin : take_results
        int unsigned w;
        if (!rst_n)
            out_stall <= 1'b0;
        else if (rx_hold != 0)
        begin
            rx_hold   <= rx_hold - 1;
            out_stall <= 1'b1;
        end
        else if (out_valid && !out_stall)
        begin
            rx_taken++;
            if (rx_taken == 250 || rx_taken == 800)
            begin
                rx_hold   <= 180;
                out_stall <= 1'b1;
            end
            else
            begin
                w = rx_burst ? 0 : $urandom_range(0, 9);
                rx_wait   <= w;
                out_stall <= (w != 0);
                if ($urandom_range(0, 29) == 0)
                    rx_burst <= !rx_burst;
            end
        end
        else if (rx_wait != 0)
        begin
            rx_wait   <= rx_wait - 1;
            out_stall <= (rx_wait != 1);
        end
        else
            out_stall <= 1'b0;
    end

    // monitor: track config, predict on input, compare on output
    always @(posedge clk)
    begin : watch
        tss_pkg::sample_t smp;
        tss_pkg::result_t want;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    tss_pkg::CFG_MODE:        mode_cfg  = cfg_data[tss_pkg::MODE_W-1:0];
                    tss_pkg::CFG_SHORT_DELAY: short_cfg = cfg_data;
                    tss_pkg::CFG_LONG_DELAY:  long_cfg  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                smp.now_ms      = now_ms;
                smp.line_ok     = line_ok;
                smp.gen_ok      = gen_ok;
                smp.line_closed = line_closed;
                smp.off_closed  = off_closed;
                smp.gen_closed  = gen_closed;
                switch_results_q.push_back(step_sequencer(smp));
            end
            if (out_valid && !out_stall)
            begin
                results_done++;
                if (switch_results_q.size() == 0)
                begin
                    $display("%0t: transaction expected none, got state %0d",
                             $time, state_code);
                    errors++;
                end
                else
                begin
                    want = switch_results_q.pop_front();
                    check_field("relay_line", want.relay_line, relay_line);
                    check_field("relay_off", want.relay_off, relay_off);
                    check_field("relay_gen", want.relay_gen, relay_gen);
                    check_field("on_line_good", want.on_line_good, on_line_good);
                    check_field("at_off_good", want.at_off_good, at_off_good);
                    check_field("on_gen_good", want.on_gen_good, on_gen_good);
                    check_field("gen_request", want.gen_request, gen_request);
                    check_field("state_code", want.state_code, state_code);
                end
            end
        end
    end

    task automatic queue_eval(input logic [tss_pkg::TIME_W-1:0] t, input logic lok,
                              input logic gok, input logic lin, input logic oin,
                              input logic gin);
        tss_pkg::sample_t smp;
        smp.now_ms      = t;
        smp.line_ok     = lok;
        smp.gen_ok      = gok;
        smp.line_closed = lin;
        smp.off_closed  = oin;
        smp.gen_closed  = gin;
        evals_q.push_back(smp);
        items_total++;
    endtask

    // sources flip now and then, the switch wanders between positions
    task automatic queue_random(input int unsigned n, input int unsigned lim_s,
                                input int unsigned lim_l);
        int unsigned scale;
        int unsigned pick;
        int unsigned adv_ms;
        int unsigned k;
        logic [2:0]  fb;
        scale = (lim_s > lim_l ? lim_s : lim_l) + 2;
        for (k = 0; k < n; k++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                adv_ms = $urandom_range(0, scale / 8 + 1);
            else if (pick < 65)
                adv_ms = $urandom_range(0, scale / 2 + 1);
            else if (pick < 78)
                adv_ms = $urandom_range(scale / 2, 2 * scale);
            else if (pick < 88)
                adv_ms = ($urandom_range(0, 1) ? lim_s : lim_l) + $urandom_range(0, 1);
            else if (pick < 97)
                adv_ms = 0;
            else
                adv_ms = $urandom;
            plant_ms = plant_ms + adv_ms;
            if ($urandom_range(0, 11) == 0)
                plant_line = !plant_line;
            if ($urandom_range(0, 9) == 0)
                plant_gen = !plant_gen;
            if ($urandom_range(0, 4) == 0)
                plant_pos = $urandom_range(0, 3);
            if ($urandom_range(0, 19) == 0)
                fb = 3'($urandom_range(0, 7));
            else
                fb = {plant_pos == 0, plant_pos == 1, plant_pos == 2};
            queue_eval(plant_ms, plant_line, plant_gen, fb[2], fb[1], fb[0]);
        end
    endtask

    // wait until every queued evaluation has come back
    task automatic settle();
        while (results_done != items_total)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [tss_pkg::CFG_IDX_W-1:0] idx,
                             input logic [tss_pkg::DELAY_W-1:0] val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic write_mode(input logic [tss_pkg::MODE_W-1:0] m);
        write_reg(tss_pkg::CFG_MODE, {{(tss_pkg::DELAY_W-tss_pkg::MODE_W){1'b0}}, m});
    endtask

    initial
    begin : stimulus
        int unsigned p;
        int unsigned s_ms;
        int unsigned l_ms;
        logic [1:0]  nf_ofs;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed walk at reset delays, strict-greater boundaries and time wrap
        queue_eval(32'd0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd5000, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd5001, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd5002, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd5003, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_eval(32'hFFFF_FFF0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_eval(32'h0000_1000, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
        queue_eval(32'h0000_2389, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'h0000_238A, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        queue_eval(32'h0000_238B, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_eval(32'h0000_4A9C, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0);
        queue_eval(32'h0000_4A9D, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        queue_eval(32'h0000_4A9E, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
        queue_eval(32'h0000_4A9F, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1);
        queue_eval(32'h0000_0000, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        // forced modes, unused codes, and auto re-entry from each
        settle();
        write_mode(tss_pkg::MODE_FORCED_GEN);
        queue_eval(32'd10, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd11, 1'b0, 1'b1, 1'b0, 1'b0, 1'b1);
        settle();
        write_mode(MODE_NO_FORCE);
        queue_eval(32'd12, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        settle();
        write_mode(tss_pkg::MODE_AUTO);
        queue_eval(32'd13, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0);
        settle();
        write_mode(tss_pkg::MODE_FORCED_LINE);
        queue_eval(32'd14, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd15, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0);
        settle();
        write_mode(MODE_NO_FORCE + 3'd3);
        queue_eval(32'd16, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();
        write_mode(tss_pkg::MODE_AUTO);
        queue_eval(32'd17, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();
        write_mode(tss_pkg::MODE_FORCED_OFF);
        queue_eval(32'd18, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        queue_eval(32'd19, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0);
        settle();
        write_mode(MODE_NO_FORCE + 3'd1);
        queue_eval(32'd20, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);
        settle();
        write_mode(tss_pkg::MODE_AUTO);
        queue_eval(32'd21, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0);

        for (p = 0; p < 14; p++)
        begin
            case (p)
                0:
                begin
                    s_ms = 0;
                    l_ms = 0;
                end
                1:
                begin
                    s_ms = 65535;
                    l_ms = 65535;
                end
                2:
                begin
                    s_ms = 0;
                    l_ms = 65535;
                end
                3:
                begin
                    s_ms = 65535;
                    l_ms = 0;
                end
                default:
                begin
                    s_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 3000);
                    l_ms = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                                       : $urandom_range(0, 3000);
                end
            endcase
            settle();
            write_reg(tss_pkg::CFG_SHORT_DELAY, s_ms[15:0]);
            write_reg(tss_pkg::CFG_LONG_DELAY, l_ms[15:0]);
            write_mode(tss_pkg::MODE_AUTO);
            queue_random($urandom_range(60, 100), s_ms, l_ms);
            if (p < 3 || $urandom_range(0, 1) == 1)
            begin
                settle();
                write_mode(forced_modes[$urandom_range(0, 2)]);
                queue_random($urandom_range(4, 10), s_ms, l_ms);
                if ($urandom_range(0, 1) == 1)
                begin
                    settle();
                    nf_ofs = 2'($urandom_range(0, 3));
                    write_mode(MODE_NO_FORCE + {1'b0, nf_ofs});
                    queue_random($urandom_range(2, 5), s_ms, l_ms);
                end
                settle();
                write_mode(tss_pkg::MODE_AUTO);
                queue_random($urandom_range(8, 16), s_ms, l_ms);
            end
        end

        settle();
        repeat (8) @(posedge clk);
        if (errors == 0)
            $display("transfer_switch_sequencer: match");
        else
            $display("transfer_switch_sequencer: mismatch");
        $finish;
    end

    initial
    begin
        #2000000;
        $display("transfer_switch_sequencer: mismatch");
        $finish;
    end

endmodule
